[design/crlf_pkg.sv]
`default_nettype none

package crlf_pkg;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    logic wr_en;
    logic restart;
    logic clr_fill;
    logic start_rd;
    logic load_rd;
    logic load_empty;
  } cmd_t;

  typedef struct packed {
    logic rx_term;
    logic fill_zero;
    logic fill_full;
    logic rd_last;
    logic out_valid;
    logic out_free;
  } sts_t;

  function automatic logic is_term(input logic [7:0] b);
    return (b == CHAR_CR) || (b == CHAR_LF);
  endfunction

endpackage

`default_nettype wire

[design/crlf_datapath.sv]
`default_nettype none

module crlf_datapath #(
  parameter int Depth = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        rx_byte_i,
  input  wire crlf_pkg::cmd_t    cmd_i,
  output crlf_pkg::sts_t         sts_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [7:0]             out_byte_o,
  output logic                   out_last_o,
  output logic                   out_empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [7:0]    mem [Depth];
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] last_idx;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q;
  logic          out_last_q;
  logic          out_empty_q;

  assign wr_addr  = cmd_i.restart ? '0 : fill_q[AW-1:0];
  assign last_idx = fill_q - CW'(1);

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.clr_fill) begin
      fill_d = '0;
    end else if (cmd_i.wr_en) begin
      fill_d = cmd_i.restart ? CW'(1) : fill_q + CW'(1);
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.start_rd) begin
      ptr_d = '0;
    end else if (cmd_i.load_rd) begin
      ptr_d = ptr_q + AW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_rd || cmd_i.load_empty) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // line store
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= rx_byte_i;
    end
  end

  // registered read doubles as the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rd) begin
      out_byte_q  <= mem[ptr_q];
      out_last_q  <= sts_o.rd_last;
      out_empty_q <= 1'b0;
    end else if (cmd_i.load_empty) begin
      out_byte_q  <= '0;
      out_last_q  <= 1'b1;
      out_empty_q <= 1'b1;
    end
  end

  assign sts_o.rx_term   = crlf_pkg::is_term(rx_byte_i);
  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.fill_full = (fill_q == CW'(Depth));
  assign sts_o.rd_last   = (ptr_q == last_idx[AW-1:0]);
  assign sts_o.out_valid = out_valid_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_empty_o = out_empty_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(Depth))
    else $error("fill count beyond store depth");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> (out_last_q && out_byte_q == 8'h00))
    else $error("empty line item malformed");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_rd || cmd_i.load_empty) |=> out_valid_q)
    else $error("loaded item not presented");
`endif

endmodule

`default_nettype wire

[design/crlf_ctrl.sv]
`default_nettype none

module crlf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire crlf_pkg::sts_t sts_i,
  output crlf_pkg::cmd_t      cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_ready_o = (state_q == ST_IDLE) && !sts_i.out_valid;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!sts_i.rx_term) begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.restart = sts_i.fill_full;
          end else if (sts_i.fill_full) begin
            // store restarted by the terminator itself
            cmd_o.load_empty = 1'b1;
            cmd_o.clr_fill   = 1'b1;
          end else if (!sts_i.fill_zero) begin
            cmd_o.start_rd = 1'b1;
            state_d        = ST_SEND;
          end
        end
      end
      ST_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.load_rd = 1'b1;
          if (sts_i.rd_last) begin
            cmd_o.clr_fill = 1'b1;
            state_d        = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_send_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND) |-> !sts_i.fill_zero)
    else $error("sending from an empty store");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND) |-> !cmd_o.wr_en)
    else $error("store written while a line is sent");

  a_send_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND && cmd_o.load_rd && sts_i.rd_last) |=> sts_i.fill_zero)
    else $error("store not emptied after line");
`endif

endmodule

`default_nettype wire

[design/crlf_line_assembler.sv]
// crlf_line_assembler: gathers received console bytes into text lines.
// input channel s_axis: one raw byte per item. CR/LF on an empty line store
// are dropped, other bytes are stored. a CR or LF after stored content ends
// the line; its bytes then leave on m_axis in order, tlast on the final one.
// a byte arriving on a full store restarts the line; if that byte is a
// terminator a single empty-line item goes out (tuser=1, tlast=1, data 0).
// once the terminator is taken the control state moves to sending and each
// store read lands in the output register; items leave one per cycle while
// m_axis_tready_i stays high.
// input is taken one byte per cycle while no line is being sent; s_axis is
// held off while sending and while an output item waits for the receiver.
// a stalled receiver freezes the output register and the read pointer.
// reset clears the fill count and control state; the store contents are
// not cleared and are never read before being written.
`default_nettype none

module crlf_line_assembler #(
  parameter int BUFFER_DEPTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] line_byte
  output logic            m_axis_tlast_o,   // last_of_line
  output logic            m_axis_tuser_o    // [0] empty_line
);

  crlf_pkg::cmd_t cmd;
  crlf_pkg::sts_t sts;

  crlf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crlf_datapath #(
    .Depth (BUFFER_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_empty_o (m_axis_tuser_o)
  );

endmodule

`default_nettype wire
